@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL of this folder.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When cond holds at a clock edge, prop must hold at the same edge.
`define ASSERT_SAME_CYCLE(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle check failed");

// When cond holds at a clock edge, prop must hold at the next edge.
`define ASSERT_NEXT_CYCLE(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/core/mps_pkg.sv @@
// Shared types, constants and fixed-point helpers of the prediction matrix stepper.
// Depends on nothing; used by every module of the stepper.
`timescale 1ns / 1ps

package mps_pkg;

   localparam int WORD_W      = 32;
   localparam int FRAC_BITS   = 24;
   localparam int PROD_W      = 2 * WORD_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int TS_W        = 31;
   localparam int HORIZON_W   = 7;
   localparam int STEP_W      = 6;
   localparam int MAX_HORIZON = 64;
   localparam int AXIS_W      = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam word_type FIX_ONE  =
      {{(WORD_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   localparam sum_type SAT_MAX = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
   localparam sum_type SAT_MIN = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
   localparam sum_type ROUND_HALF =
      {{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_TIME   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VEL_COEF_XY   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INPUT_GAIN_XY = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_VEL_COEF_Z    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INPUT_GAIN_Z  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_HORIZON_STEPS = 3'd5;

   localparam logic [TS_W-1:0]      SAMPLE_TIME_RESET = TS_W'(167772);
   localparam word_type             VEL_COEF_RESET    = FIX_ONE;
   localparam word_type             INPUT_GAIN_RESET  = '0;
   localparam logic [HORIZON_W-1:0] HORIZON_RESET     = HORIZON_W'(16);

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // Control of one axis-group datapath.
   typedef struct packed {
      logic start;    // operands are identity and b instead of the stored state
      logic capture;  // register the products of a newly accepted word
      logic commit;   // write the stepped state back
   } group_ctl_type;

   // A^(k+1) entries and the A^k b terms of one axis group.
   typedef struct packed {
      word_type pos_from_pos;
      word_type pos_from_vel;
      word_type vel_from_pos;
      word_type vel_from_vel;
      word_type imp_pos;
      word_type imp_vel;
   } group_values_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              horizon_end;
      group_values_type  xy;
      group_values_type  z;
   } result_payload_type;

   // Exact product of FIX_ONE and m.
   function automatic prod_type fx_scale_one(input word_type m);
      return {{(PROD_W-WORD_W-FRAC_BITS){m[WORD_W-1]}}, m, {FRAC_BITS{1'b0}}};
   endfunction

   // Sum of two full products, rounded to nearest (ties up) and saturated.
   function automatic word_type fx_round_sat(input prod_type a, input prod_type b);
      sum_type s;
      sum_type q;
      s = $signed({a[PROD_W-1], a}) + $signed({b[PROD_W-1], b}) + ROUND_HALF;
      q = s >>> FRAC_BITS;
      if (q > SAT_MAX) begin
         return WORD_MAX;
      end else if (q < SAT_MIN) begin
         return WORD_MIN;
      end
      return word_type'(q[WORD_W-1:0]);
   endfunction

   // Negation that saturates the most negative value.
   function automatic word_type neg_sat(input word_type v);
      if (v == WORD_MIN) begin
         return WORD_MAX;
      end
      return -v;
   endfunction

endpackage

@@ rtl/core/mps_group.sv @@
// State and datapath of one axis group: holds A^k and A^k b, steps them by A.
// Depends on mps_pkg.
`timescale 1ns / 1ps

module mps_group (
   input  logic                           clock,
   input  logic                           reset,
   input  mps_pkg::group_ctl_type         ctl,
   input  logic [mps_pkg::TS_W-1:0]       sample_time,
   input  mps_pkg::word_type              vel_coef,
   input  mps_pkg::word_type              input_gain,
   output mps_pkg::group_values_type      values
);

   mps_pkg::word_type power_ff [0:3];
   mps_pkg::word_type imp_pos_ff;
   mps_pkg::word_type imp_vel_ff;

   mps_pkg::word_type op_m [0:3];
   mps_pkg::word_type op_v_pos;
   mps_pkg::word_type op_v_vel;
   mps_pkg::word_type ts_s;
   mps_pkg::word_type a21;

   // Product stage.
   mps_pkg::word_type row0_ff [0:1];
   mps_pkg::prod_type ts_m_ff [0:1];
   mps_pkg::prod_type a_m_ff  [0:1];
   mps_pkg::prod_type c_m_ff  [0:1];
   mps_pkg::word_type cur_pos_ff;
   mps_pkg::word_type cur_vel_ff;
   mps_pkg::prod_type ts_v_ff;
   mps_pkg::prod_type a_v_ff;
   mps_pkg::prod_type c_v_ff;

   mps_pkg::prod_type ts_m_in [0:1];
   mps_pkg::prod_type a_m_in  [0:1];
   mps_pkg::prod_type c_m_in  [0:1];
   mps_pkg::prod_type ts_v_in;
   mps_pkg::prod_type a_v_in;
   mps_pkg::prod_type c_v_in;

   mps_pkg::word_type power_in [0:3];
   mps_pkg::word_type imp_pos_in;
   mps_pkg::word_type imp_vel_in;

   assign ts_s = $signed({1'b0, sample_time});
   assign a21  = mps_pkg::neg_sat(input_gain);

   // At step zero the operands are the identity matrix and b = [0, g].
   always_comb begin
      if (ctl.start) begin
         op_m[0]  = mps_pkg::FIX_ONE;
         op_m[1]  = '0;
         op_m[2]  = '0;
         op_m[3]  = mps_pkg::FIX_ONE;
         op_v_pos = '0;
         op_v_vel = input_gain;
      end else begin
         op_m[0]  = power_ff[0];
         op_m[1]  = power_ff[1];
         op_m[2]  = power_ff[2];
         op_m[3]  = power_ff[3];
         op_v_pos = imp_pos_ff;
         op_v_vel = imp_vel_ff;
      end
   end

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         ts_m_in[j] = ts_s * op_m[2+j];
         a_m_in[j]  = a21 * op_m[j];
         c_m_in[j]  = vel_coef * op_m[2+j];
      end
      ts_v_in = ts_s * op_v_vel;
      a_v_in  = a21 * op_v_pos;
      c_v_in  = vel_coef * op_v_vel;
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         row0_ff[0] <= op_m[0];
         row0_ff[1] <= op_m[1];
         for (int j = 0; j < 2; j++) begin
            ts_m_ff[j] <= ts_m_in[j];
            a_m_ff[j]  <= a_m_in[j];
            c_m_ff[j]  <= c_m_in[j];
         end
         cur_pos_ff <= op_v_pos;
         cur_vel_ff <= op_v_vel;
         ts_v_ff    <= ts_v_in;
         a_v_ff     <= a_v_in;
         c_v_ff     <= c_v_in;
      end
   end

   // Rounding and saturation of the stepped matrix and impulse vector.
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         power_in[j]   = mps_pkg::fx_round_sat(mps_pkg::fx_scale_one(row0_ff[j]),
                                               ts_m_ff[j]);
         power_in[2+j] = mps_pkg::fx_round_sat(a_m_ff[j], c_m_ff[j]);
      end
      imp_pos_in = mps_pkg::fx_round_sat(mps_pkg::fx_scale_one(cur_pos_ff), ts_v_ff);
      imp_vel_in = mps_pkg::fx_round_sat(a_v_ff, c_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff[0] <= mps_pkg::FIX_ONE;
         power_ff[1] <= '0;
         power_ff[2] <= '0;
         power_ff[3] <= mps_pkg::FIX_ONE;
         imp_pos_ff  <= '0;
         imp_vel_ff  <= '0;
      end else if (ctl.commit) begin
         for (int i = 0; i < 4; i++) begin
            power_ff[i] <= power_in[i];
         end
         imp_pos_ff <= imp_pos_in;
         imp_vel_ff <= imp_vel_in;
      end
   end

   assign values.pos_from_pos = power_in[0];
   assign values.pos_from_vel = power_in[1];
   assign values.vel_from_pos = power_in[2];
   assign values.vel_from_vel = power_in[3];
   assign values.imp_pos      = cur_pos_ff;
   assign values.imp_vel      = cur_vel_ff;

endmodule

@@ rtl/core/mps_result_buffer.sv @@
// Result register that hands out the x, y and z words of one step in turn.
// Depends on mps_pkg.
`timescale 1ns / 1ps

module mps_result_buffer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  mps_pkg::result_payload_type        payload,
   output logic                               slot_free,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mps_pkg::AXIS_W-1:0]         rsp_axis,
   output logic [mps_pkg::STEP_W-1:0]         rsp_step_index,
   output logic                               rsp_last_axis,
   output logic                               rsp_horizon_end,
   output mps_pkg::word_type                  rsp_free_pos_from_pos,
   output mps_pkg::word_type                  rsp_free_pos_from_vel,
   output mps_pkg::word_type                  rsp_free_vel_from_pos,
   output mps_pkg::word_type                  rsp_free_vel_from_vel,
   output mps_pkg::word_type                  rsp_impulse_pos,
   output mps_pkg::word_type                  rsp_impulse_vel
);

   logic                        valid_ff;
   logic                        valid_in;
   mps_pkg::axis_type           axis_ff;
   mps_pkg::axis_type           axis_in;
   mps_pkg::result_payload_type data_ff;
   mps_pkg::group_values_type   sel;
   logic                        taken;

   assign taken     = valid_ff && !rsp_stall;
   assign slot_free = !valid_ff || (taken && (axis_ff == mps_pkg::AXIS_Z));

   always_comb begin
      valid_in = valid_ff;
      axis_in  = axis_ff;
      if (load) begin
         valid_in = 1'b1;
         axis_in  = mps_pkg::AXIS_X;
      end else if (taken) begin
         case (axis_ff)
            mps_pkg::AXIS_X: begin
               axis_in = mps_pkg::AXIS_Y;
            end
            mps_pkg::AXIS_Y: begin
               axis_in = mps_pkg::AXIS_Z;
            end
            default: begin
               axis_in  = mps_pkg::AXIS_X;
               valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         axis_ff  <= mps_pkg::AXIS_X;
      end else begin
         valid_ff <= valid_in;
         axis_ff  <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= payload;
      end
   end

   assign sel = (axis_ff == mps_pkg::AXIS_Z) ? data_ff.z : data_ff.xy;

   assign rsp_valid             = valid_ff;
   assign rsp_axis              = axis_ff;
   assign rsp_step_index        = data_ff.step;
   assign rsp_last_axis         = (axis_ff == mps_pkg::AXIS_Z);
   assign rsp_horizon_end       = data_ff.horizon_end;
   assign rsp_free_pos_from_pos = sel.pos_from_pos;
   assign rsp_free_pos_from_vel = sel.pos_from_vel;
   assign rsp_free_vel_from_pos = sel.vel_from_pos;
   assign rsp_free_vel_from_vel = sel.vel_from_vel;
   assign rsp_impulse_pos       = sel.imp_pos;
   assign rsp_impulse_vel       = sel.imp_vel;

endmodule

@@ rtl/core/mpc_prediction_matrix_stepper.sv @@
// Top level of the MPC prediction matrix stepper: configuration, step counter, pipeline control.
// Depends on mps_pkg, mps_group, mps_result_buffer and assert_macros.svh.
`timescale 1ns / 1ps

// Each accepted request word advances the prediction model of a three-axis
// double integrator by one horizon step k and produces three result words, x
// first, then y, then z. Every result carries A^(k+1) (the free-response block)
// and A^k b (the impulse term) of its axis in signed Q8.24; x and y share one
// model. A request with restart set, a step past the horizon and the first word
// after reset all begin at step zero, where A is reloaded with identity and the
// impulse with b from the registers as they stand. The products of an accepted
// word are registered at the accepting edge; once the result register has a
// free slot, the sums are rounded, saturated and loaded into it, and the x
// result is presented from there, followed by y and z while the result side
// does not stall. A new request is taken as soon as the product stage has handed
// its word to the result register, which overlaps with the delivery of the
// previous step, so the pace of steps is set by the three result words per step
// on the result port. Configuration registers are written through the csr port;
// the user must write them only while the block is idle, and the block itself
// does not enforce this; an index that names no register is ignored.

`include "assert_macros.svh"

module mpc_prediction_matrix_stepper (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mps_pkg::AXIS_W-1:0]          rsp_axis,
   output logic [mps_pkg::STEP_W-1:0]          rsp_step_index,
   output logic                                rsp_last_axis,
   output logic                                rsp_horizon_end,
   output logic signed [mps_pkg::WORD_W-1:0]   rsp_free_pos_from_pos,
   output logic signed [mps_pkg::WORD_W-1:0]   rsp_free_pos_from_vel,
   output logic signed [mps_pkg::WORD_W-1:0]   rsp_free_vel_from_pos,
   output logic signed [mps_pkg::WORD_W-1:0]   rsp_free_vel_from_vel,
   output logic signed [mps_pkg::WORD_W-1:0]   rsp_impulse_pos,
   output logic signed [mps_pkg::WORD_W-1:0]   rsp_impulse_vel,
   // Configuration port
   input  logic                                csr_write,
   input  logic [mps_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [mps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers.
   logic [mps_pkg::TS_W-1:0]      sample_time_ff;
   mps_pkg::word_type             vel_coef_xy_ff;
   mps_pkg::word_type             input_gain_xy_ff;
   mps_pkg::word_type             vel_coef_z_ff;
   mps_pkg::word_type             input_gain_z_ff;
   logic [mps_pkg::HORIZON_W-1:0] horizon_ff;

   // Step control and product-stage bookkeeping.
   logic [mps_pkg::STEP_W-1:0]    step_count_ff;
   logic [mps_pkg::STEP_W-1:0]    step_count_in;
   logic                          mul_vld_ff;
   logic                          mul_vld_in;
   logic [mps_pkg::STEP_W-1:0]    step_ff;
   logic                          hend_ff;

   logic [mps_pkg::HORIZON_W-1:0] limit;
   logic [mps_pkg::HORIZON_W-1:0] step_ext;
   logic [mps_pkg::STEP_W-1:0]    step_cur;
   logic                          wrap;
   logic                          hend_cur;
   logic                          req_accept;
   logic                          slot_free;
   logic                          transfer;
   logic                          rsp_x_valid;
   logic                          rsp_z_taken;

   mps_pkg::group_ctl_type        grp_ctl;
   mps_pkg::group_values_type     xy_values;
   mps_pkg::group_values_type     z_values;
   mps_pkg::result_payload_type   payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_time_ff   <= mps_pkg::SAMPLE_TIME_RESET;
         vel_coef_xy_ff   <= mps_pkg::VEL_COEF_RESET;
         input_gain_xy_ff <= mps_pkg::INPUT_GAIN_RESET;
         vel_coef_z_ff    <= mps_pkg::VEL_COEF_RESET;
         input_gain_z_ff  <= mps_pkg::INPUT_GAIN_RESET;
         horizon_ff       <= mps_pkg::HORIZON_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mps_pkg::CSR_SAMPLE_TIME: begin
               sample_time_ff <= csr_wdata[mps_pkg::TS_W-1:0];
            end
            mps_pkg::CSR_VEL_COEF_XY: begin
               vel_coef_xy_ff <= $signed(csr_wdata);
            end
            mps_pkg::CSR_INPUT_GAIN_XY: begin
               input_gain_xy_ff <= $signed(csr_wdata);
            end
            mps_pkg::CSR_VEL_COEF_Z: begin
               vel_coef_z_ff <= $signed(csr_wdata);
            end
            mps_pkg::CSR_INPUT_GAIN_Z: begin
               input_gain_z_ff <= $signed(csr_wdata);
            end
            mps_pkg::CSR_HORIZON_STEPS: begin
               horizon_ff <= csr_wdata[mps_pkg::HORIZON_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A horizon of zero counts as one step; one above 64 is clamped to the
   // largest supported horizon.
   always_comb begin
      if (horizon_ff == '0) begin
         limit = mps_pkg::HORIZON_W'(1);
      end else if (horizon_ff > mps_pkg::HORIZON_W'(mps_pkg::MAX_HORIZON)) begin
         limit = mps_pkg::HORIZON_W'(mps_pkg::MAX_HORIZON);
      end else begin
         limit = horizon_ff;
      end
   end

   // The product stage takes a word only when it is empty, so the state it
   // reads always has the previous step written back.
   assign req_stall  = mul_vld_ff;
   assign req_accept = req_valid && !mul_vld_ff;
   assign transfer   = mul_vld_ff && slot_free;

   // A step count at or beyond the horizon (after it was lowered) restarts
   // the run as well as an explicit restart request.
   assign wrap     = req_restart || (mps_pkg::HORIZON_W'(step_count_ff) >= limit);
   assign step_cur = wrap ? '0 : step_count_ff;
   assign step_ext = mps_pkg::HORIZON_W'(step_cur);
   assign hend_cur = (step_ext == (limit - mps_pkg::HORIZON_W'(1)));

   always_comb begin
      step_count_in = step_count_ff;
      if (req_accept) begin
         if ((step_ext + mps_pkg::HORIZON_W'(1)) >= limit) begin
            step_count_in = '0;
         end else begin
            step_count_in = step_cur + mps_pkg::STEP_W'(1);
         end
      end
   end

   assign mul_vld_in = req_accept || (mul_vld_ff && !transfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= '0;
         mul_vld_ff    <= 1'b0;
      end else begin
         step_count_ff <= step_count_in;
         mul_vld_ff    <= mul_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         step_ff <= step_cur;
         hend_ff <= hend_cur;
      end
   end

   assign grp_ctl.start   = (step_cur == '0);
   assign grp_ctl.capture = req_accept;
   assign grp_ctl.commit  = transfer;

   mps_group u_group_xy (
      .clock       (clock),
      .reset       (reset),
      .ctl         (grp_ctl),
      .sample_time (sample_time_ff),
      .vel_coef    (vel_coef_xy_ff),
      .input_gain  (input_gain_xy_ff),
      .values      (xy_values)
   );

   mps_group u_group_z (
      .clock       (clock),
      .reset       (reset),
      .ctl         (grp_ctl),
      .sample_time (sample_time_ff),
      .vel_coef    (vel_coef_z_ff),
      .input_gain  (input_gain_z_ff),
      .values      (z_values)
   );

   assign payload.step        = step_ff;
   assign payload.horizon_end = hend_ff;
   assign payload.xy          = xy_values;
   assign payload.z           = z_values;

   mps_result_buffer u_result_buffer (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (transfer),
      .payload               (payload),
      .slot_free             (slot_free),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_axis              (rsp_axis),
      .rsp_step_index        (rsp_step_index),
      .rsp_last_axis         (rsp_last_axis),
      .rsp_horizon_end       (rsp_horizon_end),
      .rsp_free_pos_from_pos (rsp_free_pos_from_pos),
      .rsp_free_pos_from_vel (rsp_free_pos_from_vel),
      .rsp_free_vel_from_pos (rsp_free_vel_from_pos),
      .rsp_free_vel_from_vel (rsp_free_vel_from_vel),
      .rsp_impulse_pos       (rsp_impulse_pos),
      .rsp_impulse_vel       (rsp_impulse_vel)
   );

   assign rsp_x_valid = rsp_valid && (rsp_axis == mps_pkg::AXIS_X);
   assign rsp_z_taken = rsp_valid && !rsp_stall && (rsp_axis == mps_pkg::AXIS_Z);

   // A step handed to the result register always starts with its x word.
   `ASSERT_NEXT_CYCLE(a_load_starts_x, clock, reset, transfer, rsp_x_valid)

   // Once the z word leaves, the result side is empty unless a new step loaded.
   `ASSERT_NEXT_CYCLE(a_z_ends_step, clock, reset, rsp_z_taken && !transfer, !rsp_valid)

   // A word that enters the product stage stays there until it is handed on.
   `ASSERT_NEXT_CYCLE(a_product_holds, clock, reset, mul_vld_ff && !transfer, mul_vld_ff)

endmodule
